FILE: src/rss_pkg.sv
`default_nettype none

package rss_pkg;

	// Set geometry.
	localparam int CAPACITY  = 64;
	localparam int DRAW_BITS = 16;
	localparam int VAL_W     = 32;
	localparam int MC_W      = 7;
	localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int MOD_CNT_W = $clog2(DRAW_BITS + 1);

	// Operation codes.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_DRAW   = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_REFUSED = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_EMPTY   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_MOD,
		ST_RD_LAST,
		ST_RD_PICK,
		ST_REFUSE,
		ST_FULL,
		ST_EMPTY,
		ST_APPEND,
		ST_MOVE,
		ST_PICK
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       scan;
		logic       mod_step;
		logic       rd_last;
		logic       rd_pick;
		logic       finish;
		logic [1:0] fin_status;
		logic       fin_append;
		logic       fin_move;
		logic       fin_pick;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       scan_done;
		logic       found;
		logic       full;
		logic       empty;
		logic       mod_done;
		logic       out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: src/rss_ctrl.sv
`default_nettype none

module rss_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rss_pkg::dp_stat_t stat,
	output rss_pkg::ctrl_cmd_t     cmd
);
	import rss_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (stat.kind)
					KIND_INSERT, KIND_REMOVE: state_nxt = ST_SCAN;
					KIND_DRAW:                state_nxt = stat.empty ? ST_EMPTY : ST_MOD;
					default:                  state_nxt = ST_REFUSE;
				endcase
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					if (stat.kind == KIND_INSERT) begin
						if (stat.found)      state_nxt = ST_REFUSE;
						else if (stat.full)  state_nxt = ST_FULL;
						else                 state_nxt = ST_APPEND;
					end else begin
						state_nxt = stat.found ? ST_RD_LAST : ST_REFUSE;
					end
				end
			end
			ST_MOD: begin
				if (stat.mod_done) state_nxt = ST_RD_PICK;
			end
			ST_RD_LAST: state_nxt = ST_MOVE;
			ST_RD_PICK: state_nxt = ST_PICK;
			ST_REFUSE, ST_FULL, ST_EMPTY, ST_APPEND, ST_MOVE, ST_PICK: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:    cmd.accept   = in_valid;
			ST_SCAN:    cmd.scan     = 1'b1;
			ST_MOD:     cmd.mod_step = !stat.mod_done;
			ST_RD_LAST: cmd.rd_last  = 1'b1;
			ST_RD_PICK: cmd.rd_pick  = 1'b1;
			ST_REFUSE: begin
				cmd.finish     = stat.out_free;
				cmd.fin_status = STAT_REFUSED;
			end
			ST_FULL: begin
				cmd.finish     = stat.out_free;
				cmd.fin_status = STAT_FULL;
			end
			ST_EMPTY: begin
				cmd.finish     = stat.out_free;
				cmd.fin_status = STAT_EMPTY;
			end
			ST_APPEND: begin
				cmd.finish     = stat.out_free;
				cmd.fin_status = STAT_DONE;
				cmd.fin_append = 1'b1;
			end
			ST_MOVE: begin
				cmd.finish     = stat.out_free;
				cmd.fin_status = STAT_DONE;
				cmd.fin_move   = 1'b1;
			end
			ST_PICK: begin
				cmd.finish     = stat.out_free;
				cmd.fin_status = STAT_DONE;
				cmd.fin_pick   = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/rss_dp.sv
`default_nettype none

module rss_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire rss_pkg::ctrl_cmd_t                     cmd,
	output rss_pkg::dp_stat_t                           stat,
	input  wire logic [1:0]                             kind,
	input  wire logic signed [rss_pkg::VAL_W-1:0]       value,
	input  wire logic [rss_pkg::DRAW_BITS-1:0]          random_draw,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [1:0]                                  status,
	output logic signed [rss_pkg::VAL_W-1:0]            picked_value,
	output logic [rss_pkg::MC_W-1:0]                    member_count
);
	import rss_pkg::*;

	logic [VAL_W-1:0]     mem [CAPACITY];
	logic [VAL_W-1:0]     rd_data_q;
	logic                 rd_en;
	logic [SLOT_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_addr;
	logic [VAL_W-1:0]     wr_data;

	logic [1:0]           kind_q;
	logic [VAL_W-1:0]     value_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic [CNT_W-1:0]     last_idx;

	logic [CNT_W-1:0]     scan_addr_q;
	logic                 inflight_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic                 found_q;
	logic [SLOT_W-1:0]    pos_q;
	logic                 hit;
	logic                 scan_issue;

	logic [DRAW_BITS-1:0] draw_q;
	logic [CNT_W-1:0]     rem_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [CNT_W:0]       rem_shift;
	logic [CNT_W:0]       rem_sub;
	logic [CNT_W-1:0]     rem_nxt;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [VAL_W-1:0]     picked_q;
	logic [MC_W-1:0]      mcount_q;

	// Search over occupied slots: one read issued per cycle, compared in the cycle after.
	assign hit        = inflight_s1 && (rd_data_q == value_q);
	assign scan_issue = cmd.scan && !found_q && !hit && (scan_addr_q < count_q);

	// Restoring remainder step: one draw bit per cycle.
	assign rem_shift = {rem_q, draw_q[DRAW_BITS-1]};
	assign rem_sub   = rem_shift - {1'b0, count_q};
	assign rem_nxt   = (rem_shift >= {1'b0, count_q}) ? rem_sub[CNT_W-1:0]
	                                                   : rem_shift[CNT_W-1:0];

	assign last_idx = count_q - CNT_W'(1);

	always_comb begin
		count_nxt = count_q;
		if (cmd.finish && cmd.fin_append) count_nxt = count_q + CNT_W'(1);
		if (cmd.finish && cmd.fin_move)   count_nxt = last_idx;
	end

	// Memory port selection.
	always_comb begin
		rd_en   = scan_issue || cmd.rd_last || cmd.rd_pick;
		rd_addr = scan_addr_q[SLOT_W-1:0];
		if (cmd.rd_last) rd_addr = last_idx[SLOT_W-1:0];
		if (cmd.rd_pick) rd_addr = rem_q[SLOT_W-1:0];
		wr_en   = cmd.finish && (cmd.fin_append || cmd.fin_move);
		wr_addr = cmd.fin_move ? pos_q : count_q[SLOT_W-1:0];
		wr_data = cmd.fin_move ? rd_data_q : value_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			inflight_s1 <= 1'b0;
			scan_addr_q <= '0;
			mod_cnt_q   <= '0;
		end else begin
			count_q <= count_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.accept) begin
				found_q     <= 1'b0;
				inflight_s1 <= 1'b0;
				scan_addr_q <= '0;
				mod_cnt_q   <= '0;
			end else begin
				inflight_s1 <= scan_issue;
				if (scan_issue) scan_addr_q <= scan_addr_q + CNT_W'(1);
				if (hit) found_q <= 1'b1;
				if (cmd.mod_step) mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q  <= kind;
			value_q <= value;
			draw_q  <= random_draw;
			rem_q   <= '0;
		end else if (cmd.mod_step) begin
			draw_q <= {draw_q[DRAW_BITS-2:0], 1'b0};
			rem_q  <= rem_nxt;
		end
		if (scan_issue) idx_s1 <= scan_addr_q[SLOT_W-1:0];
		if (hit) pos_q <= idx_s1;
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
			picked_q <= cmd.fin_pick ? rd_data_q : '0;
			mcount_q <= MC_W'(count_nxt);
		end
	end

	assign stat.kind      = kind_q;
	assign stat.scan_done = found_q || (!inflight_s1 && (scan_addr_q >= count_q));
	assign stat.found     = found_q;
	assign stat.full      = (count_q >= CNT_W'(CAPACITY));
	assign stat.empty     = (count_q == '0);
	assign stat.mod_done  = (mod_cnt_q == MOD_CNT_W'(DRAW_BITS));
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign picked_value = picked_q;
	assign member_count = mcount_q;

endmodule

`default_nettype wire

FILE: src/random_sample_set_top.sv
`default_nettype none

// Channel   Direction  Handshake            Fields
// input     in         in_valid / in_stall  kind, value, random_draw
// result    out        out_valid/out_stall  status, picked_value, member_count
//
// One item is worked on at a time. Insert and remove walk the occupied slots through the
// single read port of the slot memory, one slot per cycle; a draw runs a bit-serial
// remainder over the DRAW_BITS draw bits, then a memory read. Reset clears the count and
// the result valid flag; the slot memory is not cleared, since only occupied slots are
// read. A stalled result waits in the output register while the next item is taken in and
// worked on.

module random_sample_set_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         kind,
	input  wire logic signed [rss_pkg::VAL_W-1:0]   value,
	input  wire logic [rss_pkg::DRAW_BITS-1:0]      random_draw,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [1:0]                              status,
	output logic signed [rss_pkg::VAL_W-1:0]        picked_value,
	output logic [rss_pkg::MC_W-1:0]                member_count
);
	import rss_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The controller sequences search, remainder and memory steps for each item.
	rss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the slot memory, the count and the result register.
	rss_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.value        (value),
		.random_draw  (random_draw),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.picked_value (picked_value),
		.member_count (member_count)
	);

endmodule

`default_nettype wire
